@@ rtl/core/asf_pkg.sv @@
`default_nettype none

package asf_pkg;

   // Sample and gain widths.
   localparam int SAMPLE_BITS = 24;
   localparam int GAIN_FRAC   = 16;
   localparam int AIR_BITS    = 22;
   localparam int GND_BITS    = 18;

   // Internal widths of the channel datapath.
   localparam int SUM_BITS  = SAMPLE_BITS + 4;
   localparam int LOW_BITS  = SAMPLE_BITS + 2;
   localparam int DIFF_BITS = SAMPLE_BITS + 3;
   localparam int PA_BITS   = DIFF_BITS + AIR_BITS + 1;
   localparam int PB_BITS   = LOW_BITS + GND_BITS + 1;
   localparam int ACC_BITS  = ((PA_BITS > PB_BITS) ? PA_BITS : PB_BITS) + 1;
   localparam int Y_BITS    = ACC_BITS - GAIN_FRAC;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_AIR_GAIN    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUND_GAIN = CSR_INDEX_BITS'(1);

   localparam logic [AIR_BITS-1:0] AIR_GAIN_RESET    = AIR_BITS'(65536);
   localparam logic [GND_BITS-1:0] GROUND_GAIN_RESET = GND_BITS'(65536);

   // Result queue.
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } asf_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } asf_rsp_type;

   // Lane results handed to the merge stage.
   typedef struct packed {
      logic        push;
      asf_rsp_type data;
   } asf_lane_result_type;

endpackage

`default_nettype wire

@@ rtl/core/asf_lane.sv @@
`default_nettype none

module asf_lane (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        load,
   input  wire logic signed [asf_pkg::SAMPLE_BITS-1:0] sample,
   input  wire logic [asf_pkg::AIR_BITS-1:0]          air_gain,
   input  wire logic [asf_pkg::GND_BITS-1:0]          ground_gain,
   output logic signed [asf_pkg::SAMPLE_BITS-1:0]     result
);
   import asf_pkg::*;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (GAIN_FRAC - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // History, newest sample first, and the previous raw low band.
   logic signed [SAMPLE_BITS-1:0] hist_ff [4];
   logic signed [LOW_BITS-1:0]    gprev_ff;

   logic signed [DIFF_BITS-1:0] diff_ff;
   logic signed [LOW_BITS-1:0]  low_ff;
   logic signed [PA_BITS-1:0]   prod_a_ff;
   logic signed [PB_BITS-1:0]   prod_b_ff;
   logic signed [SAMPLE_BITS-1:0] result_ff;

   logic signed [SUM_BITS-1:0]   x_w, a1_w, a2_w, a3_w, a4_w, sum;
   logic signed [LOW_BITS-1:0]   g;
   logic signed [LOW_BITS:0]     g_pair;
   logic signed [LOW_BITS-1:0]   low_in;
   logic signed [DIFF_BITS-1:0]  diff_in;
   logic signed [PA_BITS-1:0]    prod_a_in;
   logic signed [PB_BITS-1:0]    prod_b_in;
   logic signed [ACC_BITS-1:0]   acc;
   logic signed [Y_BITS-1:0]     y_w;
   logic        [Y_BITS-SAMPLE_BITS:0] y_top;
   logic signed [SAMPLE_BITS-1:0] result_in;

   always_comb begin
      x_w  = SUM_BITS'(sample);
      a1_w = SUM_BITS'(hist_ff[0]);
      a2_w = SUM_BITS'(hist_ff[1]);
      a3_w = SUM_BITS'(hist_ff[2]);
      a4_w = SUM_BITS'(hist_ff[3]);
      sum  = (x_w <<< 1) + x_w + a4_w - (a1_w <<< 1) + (a2_w <<< 2) - (a3_w <<< 1);
      // Arithmetic shifts round toward minus infinity, as the band split needs.
      g       = sum[SUM_BITS-1:2];
      g_pair  = (LOW_BITS+1)'(g) + (LOW_BITS+1)'(gprev_ff);
      low_in  = g_pair[LOW_BITS:1];
      diff_in = DIFF_BITS'(sample) - DIFF_BITS'(low_in);
   end

   always_comb begin
      prod_a_in = PA_BITS'(diff_ff) * PA_BITS'($signed({1'b0, air_gain}));
      prod_b_in = PB_BITS'(low_ff) * PB_BITS'($signed({1'b0, ground_gain}));
   end

   always_comb begin
      acc   = ACC_BITS'(prod_a_ff) + ACC_BITS'(prod_b_ff) + ROUND_HALF;
      y_w   = acc[ACC_BITS-1:GAIN_FRAC];
      y_top = y_w[Y_BITS-1:SAMPLE_BITS-1];
      if ((y_top == '0) || (y_top == '1)) begin
         result_in = y_w[SAMPLE_BITS-1:0];
      end else if (y_w[Y_BITS-1]) begin
         result_in = SAT_MIN;
      end else begin
         result_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            hist_ff[i] <= '0;
         end
         gprev_ff <= '0;
      end else if (load) begin
         hist_ff[0] <= sample;
         hist_ff[1] <= hist_ff[0];
         hist_ff[2] <= hist_ff[1];
         hist_ff[3] <= hist_ff[2];
         gprev_ff   <= g;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      low_ff    <= low_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

@@ rtl/core/asf_merge.sv @@
`default_nettype none

module asf_merge (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              accept,
   input  wire asf_pkg::asf_lane_result_type lanes,
   output logic                             full,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output asf_pkg::asf_rsp_type             rsp_data
);
   import asf_pkg::*;

   asf_rsp_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]  fill_ff, fill_in;
   // Transactions taken in and not yet delivered, pipeline included.
   logic [QUEUE_CNT_BITS-1:0]  occ_ff, occ_in;
   logic                       pop;

   assign rsp_valid = (fill_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (occ_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = lanes.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QUEUE_CNT_BITS'(lanes.push) - QUEUE_CNT_BITS'(pop);
      occ_in    = occ_ff + QUEUE_CNT_BITS'(accept) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lanes.push) begin
         queue_ff[wr_ptr_ff] <= lanes.data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/stereo_air_shelf_filter_core.sv @@
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    left_in, right_in
// rsp       out        rsp_valid/stall    left_out, right_out
// csr       in         csr_valid/ready    csr_index, csr_data
//
// One transaction is taken per cycle while req_stall is low; the left and
// right lanes each run a three-stage pipeline (band split, two multipliers,
// round and saturate) whose results are written into the result queue.
// An eight-entry result queue absorbs output stalls; req_stall rises only
// when eight transactions are in flight or waiting. Reset is synchronous
// and returns the history, low band and gains to their initial values.

module stereo_air_shelf_filter_core (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  wire asf_pkg::asf_req_type                req_data,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output asf_pkg::asf_rsp_type                     rsp_data,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire logic [asf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [asf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import asf_pkg::*;

   logic [AIR_BITS-1:0] air_gain_ff;
   logic [GND_BITS-1:0] ground_gain_ff;
   logic                accept;
   logic                full;
   logic [2:0]          vld_ff, vld_in;
   logic signed [SAMPLE_BITS-1:0] left_result;
   logic signed [SAMPLE_BITS-1:0] right_result;
   asf_lane_result_type lanes;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         air_gain_ff    <= AIR_GAIN_RESET;
         ground_gain_ff <= GROUND_GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_AIR_GAIN) begin
            air_gain_ff <= csr_data[AIR_BITS-1:0];
         end else if (csr_index == CSR_GROUND_GAIN) begin
            ground_gain_ff <= csr_data[GND_BITS-1:0];
         end
      end
   end

   assign vld_in = {vld_ff[1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   asf_lane u_lane_left (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .sample      (req_data.left_in),
      .air_gain    (air_gain_ff),
      .ground_gain (ground_gain_ff),
      .result      (left_result)
   );

   asf_lane u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .sample      (req_data.right_in),
      .air_gain    (air_gain_ff),
      .ground_gain (ground_gain_ff),
      .result      (right_result)
   );

   assign lanes = {vld_ff[2], left_result, right_result};

   asf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .lanes     (lanes),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ dv/tb_stereo_air_shelf_filter_core.sv @@
`timescale 1ns / 100ps

module tb_stereo_air_shelf_filter_core;

   import asf_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] SMAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = 24'sh800000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = CSR_INDEX_BITS'(15);
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 95;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic [CSR_INDEX_BITS-1:0]     index;
      logic [CSR_DATA_BITS-1:0]      value;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      bit                            typed;
      logic signed [SAMPLE_BITS-1:0] want_left;
      logic signed [SAMPLE_BITS-1:0] want_right;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   asf_req_type  req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   asf_rsp_type  rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // Predictor state: four taps per channel (left 0..3, right 4..7, newest first),
   // the previous raw low band per channel and the two gains.
   longint        taps [8];
   longint        band_prev [2];
   logic [AIR_BITS-1:0] air_gain_q;
   logic [GND_BITS-1:0] ground_gain_q;

   asf_rsp_type   pending_pairs [$];
   int            error_count = 0;
   int            pairs_sent = 0;
   int            pairs_checked = 0;
   int            csr_writes = 0;
   int            input_stall_cycles = 0;
   bit            tx_idle_on = 1'b0;
   bit            rsp_idle_on = 1'b0;
   int            hold_off_cycles = 0;

   dir_row_type directed_rows [24] = '{
      '{ROW_SAMPLE, '0, '0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
      '{ROW_SAMPLE, '0, '0, SMAX, SMIN, 1'b1, SMAX, SMIN},
      '{ROW_SAMPLE, '0, '0, SMIN, SMAX, 1'b1, SMIN, SMAX},
      '{ROW_SAMPLE, '0, '0, SMAX, SMAX, 1'b1, SMAX, SMAX},
      '{ROW_SAMPLE, '0, '0, SMIN, SMIN, 1'b1, SMIN, SMIN},
      '{ROW_SAMPLE, '0, '0, -24'sd1, 24'sd1, 1'b1, -24'sd1, 24'sd1},
      '{ROW_SAMPLE, '0, '0, 24'sh555555, 24'shAAAAAA, 1'b1, 24'sh555555, 24'shAAAAAA},
      '{ROW_SAMPLE, '0, '0, 24'shAAAAAA, 24'sh555555, 1'b1, 24'shAAAAAA, 24'sh555555},
      '{ROW_CSR, CSR_AIR_GAIN, 32'd0, '0, '0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_GROUND_GAIN, 32'd0, '0, '0, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, SMAX, SMIN, 1'b1, 24'sd0, 24'sd0},
      '{ROW_SAMPLE, '0, '0, 24'sh123456, 24'shEDCBAA, 1'b1, 24'sd0, 24'sd0},
      '{ROW_CSR, CSR_AIR_GAIN, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_GROUND_GAIN, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, SMAX, SMIN, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, SMIN, SMAX, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, SMAX, SMAX, 1'b0, '0, '0},
      '{ROW_CSR, CSR_UNUSED_INDEX, 32'h0001_0000, '0, '0, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 24'sd1, -24'sd1, 1'b0, '0, '0},
      '{ROW_CSR, CSR_GROUND_GAIN, 32'd131072, '0, '0, 1'b0, '0, '0},
      '{ROW_CSR, CSR_AIR_GAIN, 32'd65536, '0, '0, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, SMIN, SMIN, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 24'sd0, 24'sd0, 1'b0, '0, '0},
      '{ROW_SAMPLE, '0, '0, 24'sd1, SMAX, 1'b0, '0, '0}
   };

   stereo_air_shelf_filter_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // One channel of the shelf: band split, gain blend, round half up, saturate.
   function automatic longint shelf_channel(int ch, longint x);
      longint sum;
      longint g;
      longint low;
      longint acc;
      longint y;
      int     b;
      b   = ch * 4;
      sum = 3 * x + taps[b+3] - 2 * taps[b] + 4 * taps[b+1] - 2 * taps[b+2];
      g   = sum >>> 2;
      low = (g + band_prev[ch]) >>> 1;
      acc = (x - low) * longint'(air_gain_q) + low * longint'(ground_gain_q);
      y   = (acc + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
      taps[b+3] = taps[b+2];
      taps[b+2] = taps[b+1];
      taps[b+1] = taps[b];
      taps[b]   = x;
      band_prev[ch] = g;
      if (y > longint'(SMAX)) y = longint'(SMAX);
      if (y < longint'(SMIN)) y = longint'(SMIN);
      return y;
   endfunction

   function automatic asf_rsp_type predict_shelf_pair(asf_req_type s);
      asf_rsp_type r;
      r.left_out  = SAMPLE_BITS'(shelf_channel(0, longint'($signed(s.left_in))));
      r.right_out = SAMPLE_BITS'(shelf_channel(1, longint'($signed(s.right_in))));
      return r;
   endfunction

   // Smooth audio-like motion half the time, with extremes, full-range noise and
   // near-silence mixed in.
   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(
      logic signed [SAMPLE_BITS-1:0] last);
      logic signed [SAMPLE_BITS-1:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = SMAX;
               1: v = SMIN;
               2: v = '0;
               default: v = -24'sd1;
            endcase
         end
         1, 2: v = SAMPLE_BITS'($urandom());
         3: v = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
         default: v = last + SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
      endcase
      return v;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_AIR_GAIN:    air_gain_q = value[AIR_BITS-1:0];
         CSR_GROUND_GAIN: ground_gain_q = value[GND_BITS-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic send_sample(asf_req_type s, bit typed, asf_rsp_type typed_pair);
      asf_rsp_type predicted;
      int          gap;
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_shelf_pair(s);
      pending_pairs.push_back(typed ? typed_pair : predicted);
      pairs_sent++;
      gap = tx_idle_on ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Called at a clock edge; leaves the core empty and quiet.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Result side: a fresh hold-off per transaction, plus one long hold on request.
   initial begin
      int n;
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            n = rsp_idle_on ? $urandom_range(0, 13) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      asf_rsp_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_pairs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got %0d / %0d",
                        $time, rsp_data.left_out, rsp_data.right_out);
            end else begin
               want = pending_pairs.pop_front();
               pairs_checked++;
               if (rsp_data.left_out !== want.left_out) begin
                  error_count++;
                  $display("%0t: left_out expected %0d, got %0d",
                           $time, want.left_out, rsp_data.left_out);
               end
               if (rsp_data.right_out !== want.right_out) begin
                  error_count++;
                  $display("%0t: right_out expected %0d, got %0d",
                           $time, want.right_out, rsp_data.right_out);
               end
            end
         end
      end
   end

   initial begin
      asf_req_type                   s;
      asf_rsp_type                   typed_pair;
      logic signed [SAMPLE_BITS-1:0] last_left;
      logic signed [SAMPLE_BITS-1:0] last_right;
      logic [AIR_BITS-1:0]           air;
      logic [GND_BITS-1:0]           gnd;
      for (int i = 0; i < 8; i++) taps[i] = 0;
      band_prev[0]  = 0;
      band_prev[1]  = 0;
      air_gain_q    = AIR_GAIN_RESET;
      ground_gain_q = GROUND_GAIN_RESET;
      last_left  = '0;
      last_right = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: unity gains first, where the output equals the input.
      tx_idle_on  = 1'b1;
      rsp_idle_on = 1'b1;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_pipeline();
            write_csr(directed_rows[i].index, directed_rows[i].value);
         end else begin
            s.left_in            = directed_rows[i].left;
            s.right_in           = directed_rows[i].right;
            typed_pair.left_out  = directed_rows[i].want_left;
            typed_pair.right_out = directed_rows[i].want_right;
            send_sample(s, directed_rows[i].typed, typed_pair);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_pipeline();
         case (phase)
            0: begin air = '0; gnd = GND_BITS'(131072); end
            1: begin air = '1; gnd = '0; end
            2: begin air = '1; gnd = '1; end
            3: begin air = AIR_GAIN_RESET; gnd = GROUND_GAIN_RESET; end
            default: begin
               air = ($urandom_range(0, 1) == 0) ? AIR_BITS'($urandom_range(0, 131072))
                                                 : AIR_BITS'($urandom());
               gnd = GND_BITS'($urandom_range(0, 131072));
            end
         endcase
         // Upper bits beyond each register's width carry noise and must be dropped.
         write_csr(CSR_AIR_GAIN, ($urandom() & ~32'h003F_FFFF) | CSR_DATA_BITS'(air));
         write_csr(CSR_GROUND_GAIN, ($urandom() & ~32'h0003_FFFF) | CSR_DATA_BITS'(gnd));
         if (phase == 4) write_csr(CSR_UNUSED_INDEX, $urandom());
         tx_idle_on  = (phase % 3 != 0);
         rsp_idle_on = (phase % 4 != 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 3 && k == 10) begin
               // Hold the result side off while offering back-to-back input.
               hold_off_cycles = 64;
               tx_idle_on = 1'b0;
            end
            if (phase == 6 && k == 50) drain_pipeline();
            last_left  = draw_sample(last_left);
            last_right = draw_sample(last_right);
            s.left_in  = last_left;
            s.right_in = last_right;
            send_sample(s, 1'b0, typed_pair);
         end
      end

      rsp_idle_on = 1'b0;
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d stereo pairs with %0d register writes; %0d results checked.",
               pairs_sent, csr_writes, pairs_checked);
      $display("Input was held off for %0d cycles; %0d mismatches found.",
               input_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/asf_pkg.sv
rtl/core/asf_lane.sv
rtl/core/asf_merge.sv
rtl/core/stereo_air_shelf_filter_core.sv
dv/tb_stereo_air_shelf_filter_core.sv
